>>> rtl/core/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared constants and types of the 3x3 median filter: pixel and counter
// widths, configuration register codes and the sorted window column.
// ----------------------------------------------------------------------------
package mf3_pkg;

	// Largest supported line length and gray value width.
	localparam int MAX_WIDTH  = 1024;
	localparam int PIXEL_BITS = 8;

	// Column counter and line store address width.
	localparam int COL_W = $clog2(MAX_WIDTH);

	// Widths of the configuration registers and of the line counter.
	localparam int CFG_W_BITS = 11;
	localparam int ROW_BITS   = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;

	// Smallest frame dimension; lower settings are raised to it.
	localparam int MIN_DIM = 3;

	// Reset values of the configuration registers.
	localparam int RST_WIDTH  = 640;
	localparam int RST_HEIGHT = 480;

	// Configuration register codes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH  = 1'b0,
		REG_IMAGE_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIXEL_BITS-1:0] pix_t;

	// One window column, sorted from low to high.
	typedef struct packed {
		pix_t hi;
		pix_t md;
		pix_t lo;
	} col_t;

endpackage

>>> rtl/core/median3x3_filter_unit.sv
// ----------------------------------------------------------------------------
// median3x3_filter_unit
// Streaming 3x3 median filter over a grayscale frame in raster order.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the s_axis channel, one transaction per pixel, with tuser
// set on the first pixel of a frame. Every pixel whose line and column are
// both at least two completes the neighborhood of the interior pixel above
// and to the left of it, and one median leaves on the m_axis channel; tlast
// marks the median made by the last pixel of the frame. A frame of W x H
// pixels yields (W-2) x (H-2) medians in raster order.
// The block takes one pixel per clock while the receiver does not stall. Each
// median is formed through the line store read in stage 1, the window shift
// in stage 2 and the compare network into the output register. Two line
// stores of MAX_WIDTH entries hold the previous lines.
// When the receiver stalls, the held result backs up through the window
// stage and s_axis_tready falls once the input stage is full as well.
// Reset clears the counters, the pipeline valids and sets the frame size to
// 640 x 480; the line stores are not cleared. Configuration writes on the
// cfg channel are always taken and should be made while the block is idle.
// ----------------------------------------------------------------------------
module median3x3_filter_unit
	import mf3_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// Configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// Pixel input stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [PIXEL_BITS-1:0] s_axis_tdata,   // [7:0] pixel
	input  logic                  s_axis_tuser,   // [0] frame_start
	// Median output stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [PIXEL_BITS-1:0] m_axis_tdata,   // [7:0] median
	output logic                  m_axis_tlast    // frame_last
);

	// Small compare helpers for the selection network.
	function automatic pix_t min2(input pix_t a, input pix_t b);
		return (a < b) ? a : b;
	endfunction

	function automatic pix_t max2(input pix_t a, input pix_t b);
		return (a < b) ? b : a;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		return max2(min2(a, b), min2(max2(a, b), c));
	endfunction

	function automatic col_t sort3(input pix_t a, input pix_t b, input pix_t c);
		col_t r;
		r.lo = min2(min2(a, b), c);
		r.md = med3(a, b, c);
		r.hi = max2(max2(a, b), c);
		return r;
	endfunction

	// Configuration registers
	logic [CFG_W_BITS-1:0] width_q;
	logic [ROW_BITS-1:0]   height_q;

	// Raster counters
	logic [COL_W-1:0]    col_q;
	logic [ROW_BITS-1:0] row_q;

	// Line stores
	pix_t upper_mem [MAX_WIDTH];
	pix_t middle_mem [MAX_WIDTH];

	// Stage 1: line store read data and item flags
	logic             valid_s1;
	logic             emit_s1;
	logic             last_s1;
	pix_t             px_s1;
	pix_t             up_rd_s1;
	pix_t             mid_rd_s1;
	logic             byp_s1;
	pix_t             byp_val_s1;

	// Deferred write of the upper line store
	logic             wr_pend_q;
	logic [COL_W-1:0] wr_addr_q;

	// Stage 2: window of sorted columns
	logic valid_s2;
	logic last_s2;
	col_t win_q [3];

	// Output register
	logic out_valid_q;
	pix_t out_median_q;
	logic out_last_q;

	// Address and counter logic
	logic [CFG_W_BITS-1:0] w_eff;
	logic [CFG_W_BITS-1:0] w_last;
	logic [ROW_BITS-1:0]   h_eff;
	logic [ROW_BITS-1:0]   h_last;
	logic [COL_W-1:0]      c_raw;
	logic [ROW_BITS-1:0]   r_cur;
	logic [CFG_W_BITS-1:0] c_ext;
	logic [COL_W-1:0]      c_cur;
	logic                  line_end;
	logic                  frame_end;
	logic                  emit;

	// Handshake logic
	logic in_acc;
	logic out_adv;
	logic s2_free;
	logic s1_move;
	pix_t up_eff;
	pix_t lo_max;
	pix_t md_med;
	pix_t hi_min;

	assign cfg_ready = 1'b1;

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= CFG_W_BITS'(RST_WIDTH);
			height_q <= ROW_BITS'(RST_HEIGHT);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[CFG_W_BITS-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data[ROW_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Effective frame size: width clamped between the minimum and the line store, height raised to the minimum.
	always_comb begin
		if (width_q < CFG_W_BITS'(MIN_DIM)) begin
			w_eff = CFG_W_BITS'(MIN_DIM);
		end else if (width_q > CFG_W_BITS'(MAX_WIDTH)) begin
			w_eff = CFG_W_BITS'(MAX_WIDTH);
		end else begin
			w_eff = width_q;
		end
		h_eff  = (height_q < ROW_BITS'(MIN_DIM)) ? ROW_BITS'(MIN_DIM) : height_q;
		w_last = w_eff - CFG_W_BITS'(1);
		h_last = h_eff - ROW_BITS'(1);
	end

	// Position of the arriving pixel and the end of line and frame.
	always_comb begin
		c_raw     = s_axis_tuser ? '0 : col_q;
		r_cur     = s_axis_tuser ? '0 : row_q;
		c_ext     = (CFG_W_BITS'(c_raw) > w_last) ? w_last : CFG_W_BITS'(c_raw);
		c_cur     = c_ext[COL_W-1:0];
		line_end  = (c_ext >= w_last);
		frame_end = line_end && (r_cur >= h_last);
		emit      = (r_cur >= ROW_BITS'(2)) && (c_cur >= COL_W'(2));
	end

	// Pipeline flow: the window shifts only when stage 2 can hand on its result.
	assign out_adv       = !out_valid_q || m_axis_tready;
	assign s2_free       = !valid_s2 || out_adv;
	assign s1_move       = valid_s1 && s2_free;
	assign s_axis_tready = !valid_s1 || s2_free;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	// Raster counters advance on every accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (line_end) begin
				col_q <= '0;
				row_q <= frame_end ? '0 : r_cur + ROW_BITS'(1);
			end else begin
				col_q <= c_cur + COL_W'(1);
				row_q <= r_cur;
			end
		end
	end

	// Line stores: the middle line is read and replaced at once, the upper
	// line is written in the cycle after, with the middle data just read.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			up_rd_s1           <= upper_mem[c_cur];
			mid_rd_s1          <= middle_mem[c_cur];
			middle_mem[c_cur]  <= s_axis_tdata;
		end
		if (wr_pend_q) begin
			upper_mem[wr_addr_q] <= mid_rd_s1;
		end
	end

	// Stage 1 control and payload, with a bypass for a pending upper write
	// to the same column (a frame start right after a pixel of the first column).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			wr_pend_q <= 1'b0;
		end else begin
			wr_pend_q <= in_acc;
			if (in_acc) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1      <= s_axis_tdata;
			emit_s1    <= emit;
			last_s1    <= frame_end;
			wr_addr_q  <= c_cur;
			byp_s1     <= wr_pend_q && (wr_addr_q == c_cur);
			byp_val_s1 <= mid_rd_s1;
		end
	end

	assign up_eff = byp_s1 ? byp_val_s1 : up_rd_s1;

	// Stage 2: shift the window and insert the new column, sorted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move) begin
			valid_s2 <= emit_s1;
		end else if (out_adv) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= sort3(up_eff, mid_rd_s1, px_s1);
			last_s2  <= last_s1;
		end
	end

	// Median of nine from sorted columns.
	always_comb begin
		lo_max = max2(max2(win_q[0].lo, win_q[1].lo), win_q[2].lo);
		md_med = med3(win_q[0].md, win_q[1].md, win_q[2].md);
		hi_min = min2(min2(win_q[0].hi, win_q[1].hi), win_q[2].hi);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s2) begin
			out_median_q <= med3(lo_max, md_med, hi_min);
			out_last_q   <= last_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_median_q;
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
	// The window never shifts under a result that is still waiting.
	a_no_shift_under_result: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_adv) |-> !s1_move)
		else $error("window shifted while a result was held");

	// A held result stays in stage 2 until the output register frees.
	a_s2_held: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_adv) |=> valid_s2)
		else $error("stage 2 result lost under stall");

	// The line store address stays inside the effective line.
	a_col_in_line: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (CFG_W_BITS'(c_cur) < w_eff))
		else $error("column index beyond line width");

	// The last pixel of a frame wraps the counters to the frame origin.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && frame_end) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap at frame end");
`endif

endmodule

>>> sim/median3x3_filter_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// median3x3_filter_checker
// Watches the configuration, pixel and median channels of the 3x3 median
// filter. It keeps its own line stores, window and frame counters, works out
// the median due for every accepted pixel that completes a neighborhood, and
// compares each median transaction with the oldest one still due.
// ----------------------------------------------------------------------------
module median3x3_filter_checker
	import mf3_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_axis_tvalid,
	input  logic                  s_axis_tready,
	input  logic [PIXEL_BITS-1:0] s_axis_tdata,   // [7:0] pixel
	input  logic                  s_axis_tuser,   // [0] frame_start
	input  logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	input  logic [PIXEL_BITS-1:0] m_axis_tdata,   // [7:0] median
	input  logic                  m_axis_tlast,   // frame_last
	output int                    mismatches,
	output int                    outstanding
);

	localparam int WINDOW_TAPS = 9;
	localparam int MEDIAN_RANK = 4;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		pix_t median;
		logic frame_last;
	} median_result_t;

	median_result_t medians_due[$];

	logic [CFG_W_BITS-1:0] width_reg;
	logic [ROW_BITS-1:0]   height_reg;
	pix_t                  upper_line [MAX_WIDTH];
	pix_t                  middle_line [MAX_WIDTH];
	pix_t                  window [WINDOW_TAPS];
	int unsigned           col_pos;
	logic [ROW_BITS-1:0]   row_pos;
	int                    median_count;

	// The median is the value that has at most four smaller values and at
	// least five values not above it.
	function automatic pix_t window_median();
		int   below;
		int   not_above;
		pix_t pick;
		pick = '0;
		for (int i = 0; i < WINDOW_TAPS; i++) begin
			below = 0;
			not_above = 0;
			for (int j = 0; j < WINDOW_TAPS; j++) begin
				if (window[j] < window[i]) below++;
				if (window[j] <= window[i]) not_above++;
			end
			if (below <= MEDIAN_RANK && not_above > MEDIAN_RANK) pick = window[i];
		end
		return pick;
	endfunction

	// Advance the line stores, window and counters by one pixel.
	task automatic take_pixel(input pix_t px, input logic starts_frame);
		int unsigned         w;
		int unsigned         h;
		int unsigned         c;
		logic [COL_W-1:0]    addr;
		logic [ROW_BITS-1:0] r;
		pix_t                up;
		pix_t                mid;
		bit                  line_end;
		bit                  frame_end;
		w = 32'(width_reg);
		if (w < MIN_DIM) w = MIN_DIM;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		h = 32'(height_reg);
		if (h < MIN_DIM) h = MIN_DIM;
		if (starts_frame) begin
			col_pos = 0;
			row_pos = '0;
		end
		c = col_pos;
		r = row_pos;
		// A column left over from a wider setting maps to the last column.
		if (c >= w) c = w - 1;
		addr = c[COL_W-1:0];
		up = upper_line[addr];
		mid = middle_line[addr];
		upper_line[addr] = mid;
		middle_line[addr] = px;
		for (int k = 0; k < WINDOW_TAPS; k += 3) begin
			window[k] = window[k + 1];
			window[k + 1] = window[k + 2];
		end
		window[2] = up;
		window[5] = mid;
		window[8] = px;
		line_end = (c >= w - 1);
		frame_end = line_end && (32'(r) >= h - 1);
		if (r >= ROW_BITS'(2) && c >= 2)
			medians_due.push_back('{median: window_median(), frame_last: frame_end});
		if (line_end) begin
			col_pos = 0;
			row_pos = frame_end ? '0 : r + ROW_BITS'(1);
		end else begin
			col_pos = c + 1;
		end
	endtask

	// Compare one median transaction with the oldest median due.
	task automatic check_median(input pix_t got_median, input logic got_last);
		median_result_t due;
		if (medians_due.size() == 0) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: median transaction %0d with none due: got %0d last %0b",
					$time, median_count, got_median, got_last);
		end else begin
			due = medians_due.pop_front();
			if (due.median !== got_median || due.frame_last !== got_last) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: median transaction %0d: expected %0d last %0b, %s",
						$time, median_count, due.median, due.frame_last,
						$sformatf("got %0d last %0b", got_median, got_last));
			end
		end
		median_count++;
	endtask

	// Sample all three channels at the rising edge.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_reg = CFG_W_BITS'(RST_WIDTH);
			height_reg = ROW_BITS'(RST_HEIGHT);
			upper_line = '{default: '0};
			middle_line = '{default: '0};
			window = '{default: '0};
			col_pos = 0;
			row_pos = '0;
			median_count = 0;
			mismatches = 0;
			medians_due.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_reg_t'(cfg_index))
					REG_IMAGE_WIDTH: width_reg = cfg_data[CFG_W_BITS-1:0];
					REG_IMAGE_HEIGHT: height_reg = cfg_data[ROW_BITS-1:0];
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata, s_axis_tuser);
			if (m_axis_tvalid && m_axis_tready) check_median(m_axis_tdata, m_axis_tlast);
		end
		outstanding = medians_due.size();
	end

endmodule

>>> sim/median3x3_filter_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// median3x3_filter_unit_tb
// Drives pixel frames of many geometries into the 3x3 median filter: a few
// hand-made frames, then random frames with restarts, truncations and
// mid-frame size cuts. Both stream sides pause at random. A checker beside
// the block predicts every median.
// ----------------------------------------------------------------------------
module median3x3_filter_unit_tb;
	import mf3_pkg::*;

	localparam int RANDOM_PIXELS = 1200;
	localparam int SETTLE_CYCLES = 8;
	localparam int RESET_CYCLES  = 7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIXEL_BITS-1:0] s_axis_tdata = '0;   // [7:0] pixel
	logic                  s_axis_tuser = 1'b0; // [0] frame_start
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [PIXEL_BITS-1:0] m_axis_tdata;        // [7:0] median
	logic                  m_axis_tlast;        // frame_last

	int          mismatches;
	int          outstanding;
	bit          steady = 1'b0;
	int unsigned pixels_sent = 0;
	int unsigned frame_w = RST_WIDTH;
	int unsigned frame_h = RST_HEIGHT;

	median3x3_filter_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	median3x3_filter_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hard limit on the run time.
	initial begin
		#6_000_000;
		$display("Mismatches found");
		$finish;
	end

	function automatic int unsigned pause_length();
		return steady ? 0 : $urandom_range(0, 9);
	endfunction

	// Gray values lean toward the extremes and a narrow band so that ties occur.
	function automatic pix_t random_pixel();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return pix_t'($urandom_range(120, 135));
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	// One pixel transaction, entered and left at a falling edge.
	task automatic send_pixel(input pix_t value, input logic starts_frame);
		int unsigned gap;
		gap = pause_length();
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= starts_frame;
		do begin
			@(posedge clk);
		end while (!s_axis_tready);
		@(negedge clk);
		pixels_sent++;
	endtask

	// A run of random pixels; the first may open a frame, and with noise set
	// a stray frame start can land anywhere.
	task automatic send_run(input int unsigned count, input bit framed, input bit noisy);
		for (int unsigned i = 0; i < count; i++)
			send_pixel(random_pixel(), (framed && i == 0) || (noisy && $urandom_range(0, 15) == 0));
	endtask

	// Wait until every median due has left, then let the pipeline drain.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		@(negedge clk);
	endtask

	// Set the frame size; unused upper bits of the width write carry noise.
	task automatic configure(input int unsigned w, input int unsigned h);
		write_reg(REG_IMAGE_WIDTH, {5'($urandom_range(0, 31)), 11'(w)});
		write_reg(REG_IMAGE_HEIGHT, 16'(h));
		cfg_valid <= 1'b0;
		w = w & 32'h7FF;
		h = h & 32'hFFFF;
		frame_w = (w < MIN_DIM) ? MIN_DIM : (w > MAX_WIDTH) ? MAX_WIDTH : w;
		frame_h = (h < MIN_DIM) ? MIN_DIM : h;
	endtask

	// Receiver: random stall before every median transaction.
	initial begin
		int unsigned gap;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = pause_length();
			if (gap != 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do begin
				@(posedge clk);
			end while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	// Stimulus and verdict.
	initial begin
		int unsigned random_start;
		int unsigned w;
		int unsigned h;
		int unsigned frames;
		int unsigned area;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Smallest frame, reached by clamping zero settings up.
		configure(0, 0);
		// Five bright pixels in a checkerboard, marked as the last median.
		for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'd0 : 8'd255, i == 0);
		// Next frame by wrap-around alone, five dark pixels.
		for (int i = 0; i < 9; i++) send_pixel((i % 2) ? 8'd255 : 8'd0, 1'b0);
		// A frame cut short after two pixels, then a restart with distinct values.
		send_pixel(8'd17, 1'b1);
		send_pixel(8'd200, 1'b0);
		for (int i = 0; i < 9; i++) send_pixel(pix_t'(((i * 4) % 9) * 31), i == 0);
		settle();

		// Random frames of many sizes.
		random_start = pixels_sent;
		while (pixels_sent - random_start < RANDOM_PIXELS) begin
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 7) == 0) begin
				// Stop inside the third line or later, then cut the size so the
				// counters can sit past the new last column and line.
				send_run(2 * frame_w + $urandom_range(3, frame_w), 1'b1, 1'b0);
				settle();
				configure($urandom_range(MIN_DIM, frame_w), $urandom_range(MIN_DIM, 8));
				send_run(2 * frame_w * frame_h + $urandom_range(0, frame_w), 1'b0, 1'b0);
			end else begin
				case ($urandom_range(0, 15))
					0: w = $urandom_range(0, MIN_DIM - 1);
					1: w = $urandom_range(30, 64);
					default: w = $urandom_range(MIN_DIM, 12);
				endcase
				h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, MIN_DIM - 1)
					: $urandom_range(MIN_DIM, 8);
				configure(w, h);
				frames = $urandom_range(1, 3);
				for (int f = 0; f < frames; f++) begin
					area = frame_w * frame_h;
					case ($urandom_range(0, 7))
						0: send_run($urandom_range(1, area - 1), 1'b1, 1'b0);
						1: send_run(area, 1'b1, 1'b1);
						2: send_run(area, f == 0, 1'b0);
						default: send_run(area, 1'b1, 1'b0);
					endcase
				end
			end
			settle();
		end
		steady = 1'b0;

		if (mismatches == 0 && outstanding == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
